@@ src/assert_macros.svh @@
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define CHK_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked on every edge, reset included
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

@@ src/cpwm_pkg.sv @@
package cpwm_pkg;

  localparam int CNT_W  = 16;
  localparam int DEAD_W = 12;
  localparam int FRAC_W = 16;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [CNT_W-1:0]  PERIOD_RST    = CNT_W'(1600);
  localparam logic [CNT_W-1:0]  MIN_WIDTH_RST = CNT_W'(1);
  localparam logic [CNT_W-1:0]  MAX_WIDTH_RST = CNT_W'(1600);
  localparam logic [DEAD_W-1:0] DEAD_RST      = DEAD_W'(16);

  typedef enum logic [1:0] {
    REG_PERIOD,
    REG_MIN_WIDTH,
    REG_MAX_WIDTH,
    REG_DEAD
  } reg_idx_t;

  typedef struct packed {
    logic              load_pulse;
    logic [FRAC_W-1:0] lead_fraction;
    logic [FRAC_W-1:0] width_fraction;
    logic              drive_enable;
  } in_t;

  typedef struct packed {
    logic high_side;
    logic low_side;
    logic period_start;
    logic pulse_rejected;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0]  period;
    logic [CNT_W-1:0]  min_width;
    logic [CNT_W-1:0]  max_width;
    logic [DEAD_W-1:0] dead;
  } cfg_t;

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] lead_ticks;
    logic [CNT_W-1:0] width_ticks;
    logic             drive;
  } scaled_t;

endpackage

@@ src/cpwm_regs.sv @@
module cpwm_regs
  import cpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.period    <= PERIOD_RST;
      cfg.min_width <= MIN_WIDTH_RST;
      cfg.max_width <= MAX_WIDTH_RST;
      cfg.dead      <= DEAD_RST;
    end else if (wr) begin
      case (idx)
        REG_PERIOD:    cfg.period    <= pwdata[CNT_W-1:0];
        REG_MIN_WIDTH: cfg.min_width <= pwdata[CNT_W-1:0];
        REG_MAX_WIDTH: cfg.max_width <= pwdata[CNT_W-1:0];
        REG_DEAD:      cfg.dead      <= pwdata[DEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PERIOD:    prdata = DATA_W'(cfg.period);
      REG_MIN_WIDTH: prdata = DATA_W'(cfg.min_width);
      REG_MAX_WIDTH: prdata = DATA_W'(cfg.max_width);
      REG_DEAD:      prdata = DATA_W'(cfg.dead);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ src/cpwm_scale.sv @@
module cpwm_scale
  import cpwm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] period,
  input  logic             item_valid,
  output logic             item_ready,
  input  in_t              item,
  output logic             scaled_valid,
  input  logic             scaled_take,
  output scaled_t          scaled
);

  logic                    s1_valid;
  in_t                     s1_item;
  logic                    s1_load;
  logic                    s2_load;
  logic [FRAC_W+CNT_W-1:0] lead_prod;
  logic [FRAC_W+CNT_W-1:0] width_prod;

  assign s2_load    = s1_valid && (!scaled_valid || scaled_take);
  assign item_ready = !s1_valid || s2_load;
  assign s1_load    = item_valid && item_ready;

  // fraction times period, keep the integer part
  assign lead_prod  = s1_item.lead_fraction * period;
  assign width_prod = s1_item.width_fraction * period;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      scaled_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s2_load) begin
        s1_valid <= 1'b0;
      end
      if (s2_load) begin
        scaled_valid <= 1'b1;
      end else if (scaled_take) begin
        scaled_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item <= item;
    end
    if (s2_load) begin
      scaled.load        <= s1_item.load_pulse;
      scaled.lead_ticks  <= lead_prod[FRAC_W +: CNT_W];
      scaled.width_ticks <= width_prod[FRAC_W +: CNT_W];
      scaled.drive       <= s1_item.drive_enable;
    end
  end

endmodule

@@ src/cpwm_core.sv @@
module cpwm_core
  import cpwm_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    scaled_valid,
  output logic    scaled_take,
  input  scaled_t scaled,
  output logic    result_valid,
  input  logic    result_ready,
  output out_t    result
);

  logic [CNT_W-1:0]  tick_count, tick_count_next;
  logic [CNT_W-1:0]  pending_lead, pending_lead_next;
  logic [CNT_W-1:0]  pending_trail, pending_trail_next;
  logic [CNT_W-1:0]  active_lead, active_lead_next;
  logic [CNT_W-1:0]  active_trail, active_trail_next;
  logic              raw_high, raw_high_next;
  logic [DEAD_W-1:0] rise_delay_count, rise_delay_count_next;
  logic [DEAD_W-1:0] fall_delay_count, fall_delay_count_next;
  logic              pending_drive, pending_drive_next;
  logic              active_drive, active_drive_next;
  out_t              result_next;

  logic              start;
  logic              eff;
  logic              fed;
  logic [CNT_W-1:0]  width;
  logic [CNT_W:0]    edge_sum;
  logic [CNT_W:0]    cnt_inc;

  assign scaled_take = scaled_valid && (!result_valid || result_ready);

  always_comb begin
    start = (tick_count == '0);

    raw_high_next = raw_high;
    if (start) begin
      raw_high_next = 1'b0;
    end
    if (tick_count == active_lead) begin
      raw_high_next = 1'b1;
    end
    if (tick_count == active_trail) begin
      raw_high_next = 1'b0;
    end
    eff = active_drive && raw_high_next;

    // rising edge delay
    rise_delay_count_next = rise_delay_count;
    result_next.high_side = 1'b0;
    if (!eff) begin
      rise_delay_count_next = '0;
    end else if (rise_delay_count >= cfg.dead) begin
      result_next.high_side = 1'b1;
    end else begin
      rise_delay_count_next = rise_delay_count + DEAD_W'(1);
    end

    // falling edge delay
    fall_delay_count_next = fall_delay_count;
    if (eff) begin
      fall_delay_count_next = cfg.dead;
      fed = 1'b1;
    end else if (fall_delay_count != '0) begin
      fall_delay_count_next = fall_delay_count - DEAD_W'(1);
      fed = 1'b1;
    end else begin
      fed = 1'b0;
    end
    result_next.low_side     = active_drive ? !fed : fed;
    result_next.period_start = start;

    // width clamp and pulse staging
    width = scaled.width_ticks;
    if (width > cfg.max_width) begin
      width = cfg.max_width;
    end
    if (width < cfg.min_width) begin
      width = cfg.min_width;
    end
    edge_sum = {1'b0, scaled.lead_ticks} + {1'b0, width};

    pending_lead_next          = pending_lead;
    pending_trail_next         = pending_trail;
    result_next.pulse_rejected = 1'b0;
    if (scaled.load) begin
      if (edge_sum >= {1'b0, cfg.period}) begin
        result_next.pulse_rejected = 1'b1;
      end else begin
        pending_lead_next  = scaled.lead_ticks;
        pending_trail_next = edge_sum[CNT_W-1:0];
      end
    end
    pending_drive_next = scaled.drive;

    // period end
    cnt_inc           = {1'b0, tick_count} + (CNT_W+1)'(1);
    active_lead_next  = active_lead;
    active_trail_next = active_trail;
    active_drive_next = active_drive;
    if (cnt_inc >= {1'b0, cfg.period}) begin
      active_lead_next  = pending_lead_next;
      active_trail_next = pending_trail_next;
      active_drive_next = pending_drive_next;
      tick_count_next   = '0;
    end else begin
      tick_count_next = cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      pending_lead     <= '0;
      pending_trail    <= CNT_W'(1);
      active_lead      <= '0;
      active_trail     <= CNT_W'(1);
      raw_high         <= 1'b0;
      rise_delay_count <= '0;
      fall_delay_count <= '0;
      pending_drive    <= 1'b1;
      active_drive     <= 1'b1;
      result_valid     <= 1'b0;
    end else begin
      if (scaled_take) begin
        tick_count       <= tick_count_next;
        pending_lead     <= pending_lead_next;
        pending_trail    <= pending_trail_next;
        active_lead      <= active_lead_next;
        active_trail     <= active_trail_next;
        raw_high         <= raw_high_next;
        rise_delay_count <= rise_delay_count_next;
        fall_delay_count <= fall_delay_count_next;
        pending_drive    <= pending_drive_next;
        active_drive     <= active_drive_next;
        result_valid     <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scaled_take) begin
      result <= result_next;
    end
  end

endmodule

@@ src/complementary_pwm_dead_time.sv @@
// channel  direction  handshake                     payload
// item     in         item_valid / item_ready       in_t, one timer tick
// result   out        result_valid / result_ready   out_t, gate levels and flags
// config   in         psel penable pwrite pready    paddr, pwdata, prdata
//
// path from request to result: input register, scaling multiply register,
// then counter, dead time and staging logic into the result register
// one request per cycle when the result side keeps up
// a stalled result holds the stages behind it, ready falls only when all are full
// synchronous reset clears the counter, delay counters and valids, sets compares to lead 0, trail 1
module complementary_pwm_dead_time
  import cpwm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  in_t               item,
  output logic              result_valid,
  input  logic              result_ready,
  output out_t              result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  logic    scaled_valid;
  logic    scaled_take;
  scaled_t scaled;

  assign pready = 1'b1;

  cpwm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cpwm_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .period       (cfg.period),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .scaled_valid (scaled_valid),
    .scaled_take  (scaled_take),
    .scaled       (scaled)
  );

  cpwm_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .scaled_valid (scaled_valid),
    .scaled_take  (scaled_take),
    .scaled       (scaled),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

@@ src/cpwm_checker.sv @@
`include "assert_macros.svh"

module cpwm_checker
  import cpwm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic item_ready,
  input logic result_valid,
  input logic result_ready,
  input out_t result
);

  `CHK_ASSERT_ALWAYS(a_rst_clears_result, clk, rst |=> !result_valid)
  `CHK_ASSERT(a_ready_when_drained, clk, rst, !result_valid |-> item_ready)
  `CHK_ASSERT(a_no_shoot_through, clk, rst, result_valid |-> !(result.high_side && result.low_side))
  `CHK_ASSERT(a_result_held, clk, rst, result_valid && !result_ready |=> result_valid && $stable(result))

endmodule

bind complementary_pwm_dead_time cpwm_checker u_chk (.*);
